[rtl/dfr_pkg.sv]
`timescale 1ns / 1ps

package dfr_pkg;

  // Word and field widths
  localparam int BYTE_W = 8;
  localparam int KIND_W = 2;
  localparam int POS_W = 5;
  localparam int LEN_W = 6;
  localparam int CNT_W = 32;
  localparam int CRC_W = 16;
  localparam int CFG_IDX_W = 2;

  // Build-time defaults
  localparam int MAX_PAYLOAD_DEF = 32;
  localparam int MAX_RESULTS = 32;
  localparam int QDEPTH = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH = 2'd2;

  localparam logic [BYTE_W-1:0] SYNC_FIRST_RST = 8'hAA;
  localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h55;
  localparam logic [LEN_W-1:0] MAX_LENGTH_RST = 6'd32;

  // Event kinds
  localparam logic [KIND_W-1:0] EV_NONE = 2'd0;
  localparam logic [KIND_W-1:0] EV_BYTE = 2'd1;
  localparam logic [KIND_W-1:0] EV_CRCERR = 2'd2;
  localparam logic [KIND_W-1:0] EV_FRAMEERR = 2'd3;

  localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
  localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

  // One classified input word, handed from front to back
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [LEN_W-1:0]  length;
    logic              bank;
    logic [CNT_W-1:0]  crc_total;
    logic [CNT_W-1:0]  frm_total;
    logic [CNT_W-1:0]  good_total;
    logic              link;
  } job_t;

  // Payload store write port
  typedef struct packed {
    logic              en;
    logic              bank;
    logic [POS_W-1:0]  idx;
    logic [BYTE_W-1:0] data;
  } store_wr_t;

  // CRC-16/CCITT-FALSE, one byte, MSB first
  function automatic logic [CRC_W-1:0] crc_upd(input logic [CRC_W-1:0] crc_in,
                                               input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[CRC_W-1]) begin
        c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[rtl/dfr_byte_if.sv]
`timescale 1ns / 1ps

interface dfr_byte_if;
  logic                      valid;
  logic                      ready;
  logic [dfr_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

[rtl/dfr_cfg_if.sv]
`timescale 1ns / 1ps

interface dfr_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [dfr_pkg::CFG_IDX_W-1:0] index;
  logic [dfr_pkg::BYTE_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/dfr_result_if.sv]
`timescale 1ns / 1ps

interface dfr_result_if;
  logic                       valid;
  logic                       ready;
  logic [dfr_pkg::KIND_W-1:0] event_kind;
  logic [dfr_pkg::BYTE_W-1:0] payload_byte;
  logic [dfr_pkg::POS_W-1:0]  byte_position;
  logic [dfr_pkg::LEN_W-1:0]  frame_length;
  logic                       last_of_run;
  logic [dfr_pkg::CNT_W-1:0]  crc_error_total;
  logic [dfr_pkg::CNT_W-1:0]  framing_error_total;
  logic [dfr_pkg::CNT_W-1:0]  good_frame_total;
  logic                       link_up;

  modport source (output valid, output event_kind, output payload_byte,
                  output byte_position, output frame_length, output last_of_run,
                  output crc_error_total, output framing_error_total,
                  output good_frame_total, output link_up, input ready);
  modport sink (input valid, input event_kind, input payload_byte,
                input byte_position, input frame_length, input last_of_run,
                input crc_error_total, input framing_error_total,
                input good_frame_total, input link_up, output ready);
endinterface

[rtl/crc16_sync_frame_deframer.sv]
`timescale 1ns / 1ps
// Sync / length / payload / CRC-16 frame deframer.
// Channels: rx takes one received word per handshake; res gives result words;
// cfg writes sync_first (0), sync_second (1) and max_length (2), always ready.
// Every accepted rx word yields exactly one result word, except the second CRC
// byte of a good frame, which yields one word per payload byte, last_of_run
// marking the final one. Each result carries the counters after that word.
// A single result passes through the queue into the registered res word; a
// good frame's payload words are first read from the store, then follow one word
// per cycle while res is ready.
// Throughput: one rx word per cycle. The front parses and writes payload into
// one of two store banks; a two-entry queue feeds the back, which drains the
// store. rx stalls when the queue is full, or on a payload byte while both
// banks still hold frames that wait to drain.
// A stalled res holds its word and the back; the front runs on until the
// queue fills. Reset is synchronous: it restores the sync and length
// registers, clears counters and link-up, and returns the parser to hunting.
module crc16_sync_frame_deframer #(
  parameter int MAX_PAYLOAD_BYTES = dfr_pkg::MAX_PAYLOAD_DEF
) (
  input  logic          clk,
  input  logic          rst,
  dfr_byte_if.sink      rx,
  dfr_cfg_if.sink       cfg,
  dfr_result_if.source  res
);
  import dfr_pkg::*;

  logic      q_push, q_not_full, q_pop, q_not_empty;
  job_t      push_job, head_job;
  store_wr_t wr;
  logic [1:0] bank_free;

  // Parse, classify and fill the payload store
  dfr_front #(
    .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx),
    .cfg       (cfg),
    .q_ready   (q_not_full),
    .q_push    (q_push),
    .q_job     (push_job),
    .wr        (wr),
    .bank_free (bank_free)
  );

  // Decouple parser from result drain
  dfr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_job  (push_job),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_job  (head_job)
  );

  // Emit result words, draining good frames from the store
  dfr_back #(
    .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_not_empty),
    .q_job     (head_job),
    .q_pop     (q_pop),
    .wr        (wr),
    .bank_free (bank_free),
    .res       (res)
  );

endmodule

[rtl/dfr_front.sv]
`timescale 1ns / 1ps

module dfr_front #(
  parameter int MAX_PAYLOAD_BYTES = dfr_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                clk,
  input  logic                rst,
  dfr_byte_if.sink            rx,
  dfr_cfg_if.sink             cfg,
  input  logic                q_ready,
  output logic                q_push,
  output dfr_pkg::job_t       q_job,
  output dfr_pkg::store_wr_t  wr,
  input  logic [1:0]          bank_free
);
  import dfr_pkg::*;

  localparam int LIM = (MAX_PAYLOAD_BYTES < MAX_RESULTS) ? MAX_PAYLOAD_BYTES : MAX_RESULTS;
  localparam logic [LEN_W-1:0] LIM_V = LEN_W'(LIM);

  localparam logic [2:0] PH_SYNC1 = 3'd0;
  localparam logic [2:0] PH_SYNC2 = 3'd1;
  localparam logic [2:0] PH_LEN   = 3'd2;
  localparam logic [2:0] PH_DATA  = 3'd3;
  localparam logic [2:0] PH_CRCLO = 3'd4;
  localparam logic [2:0] PH_CRCHI = 3'd5;

  logic [BYTE_W-1:0] sync_first, sync_second;
  logic [LEN_W-1:0]  max_length;

  logic [2:0]        phase, phase_next;
  logic [LEN_W-1:0]  exp_len, exp_len_next;
  logic [LEN_W-1:0]  count, count_next;
  logic [CRC_W-1:0]  crc, crc_next;
  logic [BYTE_W-1:0] rcv_lo, rcv_lo_next;
  logic [CNT_W-1:0]  crc_tot, crc_tot_next;
  logic [CNT_W-1:0]  frm_tot, frm_tot_next;
  logic [CNT_W-1:0]  good_tot, good_tot_next;
  logic              link, link_next;
  logic              wbank, wbank_next;
  logic [1:0]        bank_busy, busy_set;
  logic [KIND_W-1:0] kind;
  logic [LEN_W-1:0]  limit;
  logic [BYTE_W-1:0] b;
  logic              accept;

  assign b      = rx.rx_byte;
  assign limit  = (max_length > LIM_V) ? LIM_V : max_length;
  // Hold payload bytes while the bank to fill is still being drained
  assign rx.ready = q_ready && !((phase == PH_DATA) && bank_busy[wbank]);
  assign accept = rx.valid && rx.ready;
  assign cfg.ready = 1'b1;

  always_comb begin
    phase_next    = phase;
    exp_len_next  = exp_len;
    count_next    = count;
    crc_next      = crc;
    rcv_lo_next   = rcv_lo;
    crc_tot_next  = crc_tot;
    frm_tot_next  = frm_tot;
    good_tot_next = good_tot;
    link_next     = link;
    wbank_next    = wbank;
    busy_set      = 2'b00;
    kind          = EV_NONE;
    wr            = '0;
    case (phase)
      PH_SYNC2: begin
        if (b == sync_second) begin
          phase_next = PH_LEN;
        end else if (b != sync_first) begin
          phase_next = PH_SYNC1;
        end
      end
      PH_LEN: begin
        if (b == '0 || b > {2'b00, limit}) begin
          frm_tot_next = frm_tot + 32'd1;
          phase_next   = PH_SYNC1;
          kind         = EV_FRAMEERR;
        end else begin
          exp_len_next = b[LEN_W-1:0];
          count_next   = '0;
          crc_next     = crc_upd(CRC_INIT, b);
          phase_next   = PH_DATA;
        end
      end
      PH_DATA: begin
        wr.en      = 1'b1;
        wr.bank    = wbank;
        wr.idx     = count[POS_W-1:0];
        wr.data    = b;
        crc_next   = crc_upd(crc, b);
        count_next = count + 6'd1;
        if (count_next >= exp_len) begin
          phase_next = PH_CRCLO;
        end
      end
      PH_CRCLO: begin
        rcv_lo_next = b;
        phase_next  = PH_CRCHI;
      end
      PH_CRCHI: begin
        phase_next = PH_SYNC1;
        if ({b, rcv_lo} != crc) begin
          crc_tot_next = crc_tot + 32'd1;
          kind         = EV_CRCERR;
        end else begin
          good_tot_next     = good_tot + 32'd1;
          link_next         = 1'b1;
          kind              = EV_BYTE;
          busy_set[wbank]   = 1'b1;
          wbank_next        = ~wbank;
        end
      end
      default: begin
        phase_next = (b == sync_first) ? PH_SYNC2 : PH_SYNC1;
      end
    endcase
    if (!accept) begin
      wr.en = 1'b0;
    end
  end

  assign q_push           = accept;
  assign q_job.kind       = kind;
  assign q_job.length     = exp_len;
  assign q_job.bank       = wbank;
  assign q_job.crc_total  = crc_tot_next;
  assign q_job.frm_total  = frm_tot_next;
  assign q_job.good_total = good_tot_next;
  assign q_job.link       = link_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first  <= SYNC_FIRST_RST;
      sync_second <= SYNC_SECOND_RST;
      max_length  <= MAX_LENGTH_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_SYNC_FIRST:  sync_first  <= cfg.data;
        REG_SYNC_SECOND: sync_second <= cfg.data;
        REG_MAX_LENGTH:  max_length  <= cfg.data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_SYNC1;
      exp_len   <= '0;
      count     <= '0;
      crc       <= CRC_INIT;
      rcv_lo    <= '0;
      crc_tot   <= '0;
      frm_tot   <= '0;
      good_tot  <= '0;
      link      <= 1'b0;
      wbank     <= 1'b0;
      bank_busy <= 2'b00;
    end else begin
      bank_busy <= (bank_busy & ~bank_free) | (accept ? busy_set : 2'b00);
      if (accept) begin
        phase    <= phase_next;
        exp_len  <= exp_len_next;
        count    <= count_next;
        crc      <= crc_next;
        rcv_lo   <= rcv_lo_next;
        crc_tot  <= crc_tot_next;
        frm_tot  <= frm_tot_next;
        good_tot <= good_tot_next;
        link     <= link_next;
        wbank    <= wbank_next;
      end
    end
  end

endmodule

[rtl/dfr_queue.sv]
`timescale 1ns / 1ps

module dfr_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  dfr_pkg::job_t  push_job,
  output logic           not_full,
  input  logic           pop,
  output logic           not_empty,
  output dfr_pkg::job_t  head_job
);
  import dfr_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  job_t          slots [QDEPTH];
  logic [PW-1:0] wptr, rptr;
  logic [CW-1:0] fill;
  logic          do_push, do_pop;

  assign not_full  = (fill != CW'(QDEPTH));
  assign not_empty = (fill != '0);
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;
  assign head_job  = slots[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(QDEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(QDEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

[rtl/dfr_back.sv]
`timescale 1ns / 1ps

module dfr_back #(
  parameter int MAX_PAYLOAD_BYTES = dfr_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  dfr_pkg::job_t       q_job,
  output logic                q_pop,
  input  dfr_pkg::store_wr_t  wr,
  output logic [1:0]          bank_free,
  dfr_result_if.source        res
);
  import dfr_pkg::*;

  localparam int LIM = (MAX_PAYLOAD_BYTES < MAX_RESULTS) ? MAX_PAYLOAD_BYTES : MAX_RESULTS;
  localparam int AW = (LIM > 1) ? $clog2(LIM) : 1;
  localparam int MEM_DEPTH = 2 << AW;

  localparam logic BK_IDLE  = 1'b0;
  localparam logic BK_DRAIN = 1'b1;

  logic [BYTE_W-1:0] mem [MEM_DEPTH];
  logic [BYTE_W-1:0] rd_data;
  logic [AW:0]       rd_addr;
  logic              rd_en;
  logic              state;
  logic [POS_W-1:0]  idx;
  logic              free, last;
  logic              load;

  assign free = !res.valid || res.ready;
  assign last = (({1'b0, idx} + 6'd1) == q_job.length);

  always_comb begin
    rd_en     = 1'b0;
    rd_addr   = '0;
    q_pop     = 1'b0;
    load      = 1'b0;
    bank_free = 2'b00;
    case (state)
      BK_IDLE: begin
        if (q_valid && free) begin
          if (q_job.kind == EV_BYTE) begin
            rd_en   = 1'b1;
            rd_addr = {q_job.bank, {AW{1'b0}}};
          end else begin
            q_pop = 1'b1;
            load  = 1'b1;
          end
        end
      end
      BK_DRAIN: begin
        if (free) begin
          load = 1'b1;
          if (last) begin
            q_pop                = 1'b1;
            bank_free[q_job.bank] = 1'b1;
          end else begin
            rd_en   = 1'b1;
            rd_addr = {q_job.bank, AW'(idx + 5'd1)};
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[{wr.bank, wr.idx[AW-1:0]}] <= wr.data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      idx       <= '0;
      res.valid <= 1'b0;
    end else begin
      // Raise valid on a new word, drop it once the word is taken
      res.valid <= load || (res.valid && !res.ready);
      case (state)
        BK_IDLE: begin
          if (q_valid && free && q_job.kind == EV_BYTE) begin
            idx   <= '0;
            state <= BK_DRAIN;
          end
        end
        BK_DRAIN: begin
          if (free) begin
            if (last) begin
              state <= BK_IDLE;
            end else begin
              idx <= idx + 5'd1;
            end
          end
        end
        default: state <= BK_IDLE;
      endcase
    end
  end

  // Result payload, loaded together with valid
  always_ff @(posedge clk) begin
    if (load) begin
      res.crc_error_total     <= q_job.crc_total;
      res.framing_error_total <= q_job.frm_total;
      res.good_frame_total    <= q_job.good_total;
      res.link_up             <= q_job.link;
      if (state == BK_DRAIN) begin
        res.event_kind    <= EV_BYTE;
        res.payload_byte  <= rd_data;
        res.byte_position <= idx;
        res.frame_length  <= q_job.length;
        res.last_of_run   <= last;
      end else begin
        res.event_kind    <= q_job.kind;
        res.payload_byte  <= '0;
        res.byte_position <= '0;
        res.frame_length  <= '0;
        res.last_of_run   <= 1'b1;
      end
    end
  end

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps

module tb;
  import dfr_pkg::*;

  // Spare register index: the block must ignore writes to it
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  // Cycles with no handshake on any channel before the run is called hung
  localparam int STALL_LIMIT = 4000;

  // Parser phases of the deframer prediction
  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_SYNC2 = 3'd1,
    PH_LEN   = 3'd2,
    PH_DATA  = 3'd3,
    PH_CRCLO = 3'd4,
    PH_CRCHI = 3'd5
  } parse_phase_t;

  // One result word as the block should present it
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] data;
    logic [POS_W-1:0]  pos;
    logic [LEN_W-1:0]  len;
    logic              last;
    logic [CNT_W-1:0]  crc_tot;
    logic [CNT_W-1:0]  frm_tot;
    logic [CNT_W-1:0]  good_tot;
    logic              link;
  } res_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  dfr_byte_if   rx_ch ();
  dfr_cfg_if    cfg_ch ();
  dfr_result_if res_ch ();

  crc16_sync_frame_deframer u_dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_ch),
    .cfg (cfg_ch),
    .res (res_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Bytes waiting to go out on rx, and result words still owed by the block
  logic [BYTE_W-1:0] pending_bytes [$];
  res_word_t         expected_words [$];
  int                queued_total;

  int send_idle_pct;
  int recv_idle_pct;
  int errors;
  int quiet_cycles;

  // Predicted register file and parser state
  logic [BYTE_W-1:0] cfg_sync_first;
  logic [BYTE_W-1:0] cfg_sync_second;
  logic [LEN_W-1:0]  cfg_max_length;

  parse_phase_t      phase;
  logic [LEN_W-1:0]  want_len;
  logic [LEN_W-1:0]  got_cnt;
  logic [BYTE_W-1:0] payload_mem [MAX_PAYLOAD_DEF];
  logic [CRC_W-1:0]  crc_acc;
  logic [CRC_W-1:0]  crc_seen;
  logic [CNT_W-1:0]  crc_err_cnt;
  logic [CNT_W-1:0]  frm_err_cnt;
  logic [CNT_W-1:0]  good_cnt;
  logic              link_seen;

  // CRC-16/CCITT-FALSE over one byte, MSB first
  function automatic logic [CRC_W-1:0] crc16_step(input logic [CRC_W-1:0] c_in,
                                                  input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = c_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[CRC_W-1] ? ({c[CRC_W-2:0], 1'b0} ^ 16'h1021) : {c[CRC_W-2:0], 1'b0};
    end
    return c;
  endfunction

  // Largest length the parser takes under the current max_length
  function automatic int length_cap();
    int cap;
    cap = cfg_max_length;
    if (cap > MAX_PAYLOAD_DEF) cap = MAX_PAYLOAD_DEF;
    if (cap > MAX_RESULTS) cap = MAX_RESULTS;
    return cap;
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [BYTE_W-1:0] val);
    case (idx)
      REG_SYNC_FIRST:  cfg_sync_first = val;
      REG_SYNC_SECOND: cfg_sync_second = val;
      REG_MAX_LENGTH:  cfg_max_length = val[LEN_W-1:0];
      default: ;
    endcase
  endfunction

  // Advance the parser by one received byte and queue the words it owes
  function automatic void deframe_byte(input logic [BYTE_W-1:0] b);
    res_word_t         w;
    logic [KIND_W-1:0] kind;
    int                n;
    kind = EV_NONE;
    case (phase)
      PH_SYNC2: begin
        // second sync wins over a repeated first sync when both are equal
        if (b == cfg_sync_second) phase = PH_LEN;
        else if (b != cfg_sync_first) phase = PH_HUNT;
      end
      PH_LEN: begin
        if (b == 0 || int'(b) > length_cap()) begin
          frm_err_cnt = frm_err_cnt + 1;
          phase = PH_HUNT;
          kind = EV_FRAMEERR;
        end else begin
          want_len = b[LEN_W-1:0];
          got_cnt = '0;
          crc_acc = crc16_step(CRC_INIT, b);
          phase = PH_DATA;
        end
      end
      PH_DATA: begin
        if (got_cnt < MAX_PAYLOAD_DEF) payload_mem[got_cnt[POS_W-1:0]] = b;
        crc_acc = crc16_step(crc_acc, b);
        got_cnt = got_cnt + 1'b1;
        if (got_cnt >= want_len) phase = PH_CRCLO;
      end
      PH_CRCLO: begin
        crc_seen = {8'h00, b};
        phase = PH_CRCHI;
      end
      PH_CRCHI: begin
        crc_seen[CRC_W-1:8] = b;
        phase = PH_HUNT;
        if (crc_seen != crc_acc) begin
          crc_err_cnt = crc_err_cnt + 1;
          kind = EV_CRCERR;
        end else begin
          good_cnt = good_cnt + 1;
          link_seen = 1'b1;
          kind = EV_BYTE;
        end
      end
      default: phase = (b == cfg_sync_first) ? PH_SYNC2 : PH_HUNT;
    endcase

    w.crc_tot = crc_err_cnt;
    w.frm_tot = frm_err_cnt;
    w.good_tot = good_cnt;
    w.link = link_seen;
    if (kind == EV_BYTE) begin
      // good frame: drain the payload as a run, last mark on the final word
      n = want_len;
      if (n > MAX_PAYLOAD_DEF) n = MAX_PAYLOAD_DEF;
      if (n > MAX_RESULTS) n = MAX_RESULTS;
      for (int i = 0; i < n; i++) begin
        w.kind = EV_BYTE;
        w.data = payload_mem[i];
        w.pos = POS_W'(i);
        w.len = LEN_W'(n);
        w.last = (i + 1 == n);
        expected_words.push_back(w);
      end
    end else begin
      w.kind = kind;
      w.data = '0;
      w.pos = '0;
      w.len = '0;
      w.last = 1'b1;
      expected_words.push_back(w);
    end
  endfunction

  // Driver: hold a word until rx takes it, then offer the next or idle
  always @(posedge clk) begin
    if (rst) begin
      rx_ch.valid <= 1'b0;
      rx_ch.rx_byte <= '0;
    end else begin
      if (rx_ch.valid && rx_ch.ready) deframe_byte(rx_ch.rx_byte);
      if (!rx_ch.valid || rx_ch.ready) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          rx_ch.valid <= 1'b1;
          rx_ch.rx_byte <= pending_bytes.pop_front();
        end else begin
          rx_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each taken word against the oldest one owed
  always @(posedge clk) begin
    res_word_t got;
    res_word_t want;
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        got.kind = res_ch.event_kind;
        got.data = res_ch.payload_byte;
        got.pos = res_ch.byte_position;
        got.len = res_ch.frame_length;
        got.last = res_ch.last_of_run;
        got.crc_tot = res_ch.crc_error_total;
        got.frm_tot = res_ch.framing_error_total;
        got.good_tot = res_ch.good_frame_total;
        got.link = res_ch.link_up;
        if (expected_words.size() == 0) begin
          if (errors < 10)
            $display("unexpected word: kind %0d byte %02h pos %0d len %0d last %0b",
                     got.kind, got.data, got.pos, got.len, got.last);
          errors++;
        end else begin
          want = expected_words.pop_front();
          if (got.kind !== want.kind || got.data !== want.data || got.pos !== want.pos ||
              got.len !== want.len || got.last !== want.last ||
              got.crc_tot !== want.crc_tot || got.frm_tot !== want.frm_tot ||
              got.good_tot !== want.good_tot || got.link !== want.link) begin
            if (errors < 10) begin
              $display("mismatch exp: kind %0d byte %02h pos %0d len %0d last %0b crc %0d frm %0d good %0d link %0b",
                       want.kind, want.data, want.pos, want.len, want.last,
                       want.crc_tot, want.frm_tot, want.good_tot, want.link);
              $display("         got: kind %0d byte %02h pos %0d len %0d last %0b crc %0d frm %0d good %0d link %0b",
                       got.kind, got.data, got.pos, got.len, got.last,
                       got.crc_tot, got.frm_tot, got.good_tot, got.link);
            end
            errors++;
          end
        end
      end
      res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: any handshake counts as progress
  always @(posedge clk) begin
    if (rst || (rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic void push_byte(input logic [BYTE_W-1:0] b);
    pending_bytes.push_back(b);
    queued_total++;
  endfunction

  // Queue one frame; fill < 0 means random payload, dup adds repeated first syncs
  function automatic void push_frame(input int len, input bit corrupt, input int fill,
                                     input int dup);
    logic [BYTE_W-1:0] b;
    logic [CRC_W-1:0]  c;
    c = CRC_INIT;
    push_byte(cfg_sync_first);
    for (int i = 0; i < dup; i++) push_byte(cfg_sync_first);
    push_byte(cfg_sync_second);
    push_byte(BYTE_W'(len));
    c = crc16_step(c, BYTE_W'(len));
    for (int i = 0; i < len; i++) begin
      b = (fill < 0) ? BYTE_W'($urandom) : BYTE_W'(fill);
      push_byte(b);
      c = crc16_step(c, b);
    end
    if (corrupt) c = c ^ CRC_W'($urandom_range(1, 16'hFFFF));
    push_byte(c[7:0]);
    push_byte(c[15:8]);
  endfunction

  // Mostly short frames, now and then up to the cap
  function automatic int pick_len();
    int cap;
    cap = length_cap();
    if (cap == 0) return $urandom_range(1, 8);
    if ($urandom_range(99) < 85) return $urandom_range(1, (cap < 8) ? cap : 8);
    return $urandom_range(1, cap);
  endfunction

  // Random traffic: well-formed frames with random content, plus broken ones
  function automatic void gen_traffic(input int count);
    int start;
    int r;
    int len;
    int cap;
    start = queued_total;
    cap = length_cap();
    if (cap > 0) push_frame(cap, 1'b0, -1, 0);
    while (queued_total - start < count) begin
      r = $urandom_range(99);
      if (r < 58) begin
        push_frame(pick_len(), 1'b0, -1, 0);
      end else if (r < 68) begin
        push_frame(pick_len(), 1'b1, -1, 0);
      end else if (r < 76) begin
        // bad length byte: zero or above the cap
        push_byte(cfg_sync_first);
        push_byte(cfg_sync_second);
        if ($urandom_range(1) == 0) push_byte(8'h00);
        else push_byte(BYTE_W'($urandom_range(cap + 1, 255)));
      end else if (r < 84) begin
        push_frame(pick_len(), 1'b0, -1,
                   (cfg_sync_first != cfg_sync_second) ? $urandom_range(1, 3) : 0);
      end else if (r < 90) begin
        // frame cut short; the next bytes get eaten as its tail
        len = pick_len();
        push_byte(cfg_sync_first);
        push_byte(cfg_sync_second);
        push_byte(BYTE_W'(len));
        repeat ($urandom_range(0, len - 1)) push_byte(BYTE_W'($urandom));
      end else begin
        repeat ($urandom_range(1, 4)) push_byte(BYTE_W'($urandom));
      end
    end
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    apply_reg(idx, val);
    cfg_ch.valid <= 1'b0;
  endtask

  // Sample at the falling edge so the posedge processes have all settled
  task automatic wait_drained();
    @(negedge clk);
    while (pending_bytes.size() != 0 || rx_ch.valid || expected_words.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    int p;
    int cnt;
    logic [BYTE_W-1:0] sf_v;
    logic [BYTE_W-1:0] ss_v;
    logic [BYTE_W-1:0] ml_v;

    rx_ch.valid = 1'b0;
    rx_ch.rx_byte = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    res_ch.ready = 1'b0;
    queued_total = 0;
    errors = 0;
    quiet_cycles = 0;
    send_idle_pct = 33;
    recv_idle_pct = 62;

    cfg_sync_first = SYNC_FIRST_RST;
    cfg_sync_second = SYNC_SECOND_RST;
    cfg_max_length = MAX_LENGTH_RST;
    phase = PH_HUNT;
    want_len = '0;
    got_cnt = '0;
    crc_acc = CRC_INIT;
    crc_seen = '0;
    crc_err_cnt = '0;
    frm_err_cnt = '0;
    good_cnt = '0;
    link_seen = 1'b0;
    for (int i = 0; i < MAX_PAYLOAD_DEF; i++) payload_mem[i] = '0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // spare index must leave every register alone
    write_reg(REG_SPARE, BYTE_W'($urandom));

    // Directed words under the reset register values
    push_byte(8'h00);
    push_byte(8'hFF);
    push_frame(1, 1'b0, 8'hFF, 1);   // repeated first sync, one-byte frame
    push_byte(cfg_sync_first);       // zero length
    push_byte(cfg_sync_second);
    push_byte(8'h00);
    push_byte(cfg_sync_first);       // one past the cap
    push_byte(cfg_sync_second);
    push_byte(8'h21);
    push_frame(2, 1'b1, 8'h00, 0);   // crc mismatch
    push_byte(cfg_sync_first);       // wrong second sync drops back to hunting
    push_byte(8'h13);
    wait_drained();

    for (p = 1; p <= 6; p++) begin
      case (p)
        1: begin sf_v = 8'hAA; ss_v = 8'h55; ml_v = 8'd32; end
        2: begin sf_v = 8'h00; ss_v = 8'hFF; ml_v = 8'd1; end
        3: begin sf_v = 8'hFF; ss_v = 8'h00; ml_v = 8'd63; end
        4: begin sf_v = 8'h5A; ss_v = 8'h5A; ml_v = 8'd16; end
        5: begin sf_v = BYTE_W'($urandom); ss_v = BYTE_W'($urandom); ml_v = 8'd0; end
        default: begin
          sf_v = BYTE_W'($urandom);
          ss_v = BYTE_W'($urandom);
          ml_v = BYTE_W'($urandom_range(1, 32));
        end
      endcase
      if (p <= 2) begin
        send_idle_pct = 33;
        recv_idle_pct = 62;
      end else if (p <= 4) begin
        send_idle_pct = 62;
        recv_idle_pct = 33;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_reg(REG_SYNC_FIRST, sf_v);
      write_reg(REG_SYNC_SECOND, ss_v);
      write_reg(REG_MAX_LENGTH, ml_v);
      cnt = (p == 5) ? 60 : 80;
      @(negedge clk);
      gen_traffic(cnt);
      wait_drained();
    end

    // let any stray word surface before the verdict
    repeat (8) @(posedge clk);
    if (expected_words.size() != 0) errors++;
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
